/* sv/htw_pkg.sv */
package htw_pkg;

  // BUCKETS must be a power of two: the bucket is the low bits of the expiry tick
  localparam int ENTRIES = 64;
  localparam int BUCKETS = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int PTR_W   = IDX_W + 1;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam logic [PTR_W-1:0] NONE = PTR_W'(ENTRIES);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_CANCEL = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_EXPIRY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_CAN_CHK,
    ST_TICK_CHK,
    ST_SCAN,
    ST_SCAN_END,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_UNLINK,
    ST_RELEASE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic               defer;
    logic [15:0]        delay;
    logic [5:0]         handle;
    logic [15:0]        callback_id;
    logic signed [31:0] callback_arg;
  } in_t;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [5:0]         entry;
    logic [15:0]        action_id;
    logic signed [31:0] action_arg;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [31:0]        expiry;
    logic [15:0]        action;
    logic signed [31:0] argument;
  } ent_t;

endpackage

/* sv/hashed_timer_wheel.sv */
// Timer wheel over a pool of ENTRIES timers in BUCKETS hashed lists, driven by
// start/busy commands. A cancel whose entry matches walks its bucket, reading
// and checking each entry visited. A tick that fires scans all ENTRIES of the
// entry memory (one read a cycle) for the due time of each fired timer, then
// walks that bucket, reading each entry visited, and ends with the
// unlink and release; every processed tick ends with a scan that finds nothing
// and a flush step. Results come out on out_valid for one cycle each and must
// be taken when shown: there is no back-pressure. Expiry events of one tick are
// held back one step so that the final one can carry last.
module hashed_timer_wheel
  import htw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  state_t state_r, state_nxt;
  in_t    req_r, req_nxt;
  logic [31:0] now_r, now_nxt, ndt_r, ndt_nxt, span_r, span_nxt, best_r, best_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic        any_r, any_nxt, fire_r, fire_nxt;
  logic [PTR_W-1:0] free_r, free_nxt, idx_r, idx_nxt, cur_r, cur_nxt, prev_r, prev_nxt;
  logic [PTR_W-1:0] nl_r, nl_nxt;
  logic [BKT_W-1:0] bkt_r, bkt_nxt;
  logic [PTR_W-1:0] bhead_r [BUCKETS];
  logic [PTR_W-1:0] bhead_nxt [BUCKETS];
  logic [ENTRIES-1:0] act_r, act_nxt;
  out_t pend_r, pend_nxt, out_r, out_nxt;
  logic pend_v_r, pend_v_nxt, out_v_r, out_v_nxt;

  // entry store and link store, one port each, registered read
  ent_t             ent_mem [ENTRIES];
  ent_t             ent_q_r;
  logic [IDX_W-1:0] ent_addr;
  logic             ent_we;
  ent_t             ent_wd;

  logic [PTR_W-1:0] lnk_mem [ENTRIES];
  logic [ENTRIES-1:0] lnk_ok_r;
  logic [PTR_W-1:0] lnk_raw_r, lnk_dflt_r, lnk_rd;
  logic             lnk_okq_r;
  logic [IDX_W-1:0] lnk_addr;
  logic             lnk_we;
  logic [PTR_W-1:0] lnk_wd;

  logic [31:0] diff, exp_sum, d_off;
  logic [15:0] dly;
  logic [IDX_W-1:0] j;
  logic hit;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= ent_wd;
    end
    ent_q_r <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_addr] <= lnk_wd;
    end
    lnk_raw_r  <= lnk_mem[lnk_addr];
    lnk_okq_r  <= lnk_ok_r[lnk_addr];
    lnk_dflt_r <= PTR_W'(lnk_addr) + PTR_W'(1);
  end

  // unwritten link entries read as the reset chain
  assign lnk_rd = lnk_okq_r ? lnk_raw_r : lnk_dflt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      now_r    <= '0;
      ndt_r    <= 32'd1;
      free_r   <= '0;
      act_r    <= '0;
      lnk_ok_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        bhead_r[b] <= NONE;
      end
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      ndt_r    <= ndt_nxt;
      free_r   <= free_nxt;
      act_r    <= act_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      bhead_r  <= bhead_nxt;
      if (lnk_we) begin
        lnk_ok_r[lnk_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    span_r <= span_nxt;
    best_r <= best_nxt;
    tick_r <= tick_nxt;
    any_r  <= any_nxt;
    fire_r <= fire_nxt;
    idx_r  <= idx_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    nl_r   <= nl_nxt;
    bkt_r  <= bkt_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign diff    = now_r - ndt_r;
  assign dly     = (req_r.delay == 16'd0) ? 16'd1 : req_r.delay;
  assign exp_sum = now_r + {16'd0, dly};
  assign d_off   = ent_q_r.expiry - ndt_r;
  assign j       = IDX_W'(idx_r - PTR_W'(1));
  assign hit     = fire_r ? (act_r[cur_r[IDX_W-1:0]] && ent_q_r.expiry == tick_r)
                          : (cur_r == PTR_W'(req_r.handle));

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    now_nxt    = now_r;
    ndt_nxt    = ndt_r;
    span_nxt   = span_r;
    best_nxt   = best_r;
    tick_nxt   = tick_r;
    any_nxt    = any_r;
    fire_nxt   = fire_r;
    free_nxt   = free_r;
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    nl_nxt     = nl_r;
    bkt_nxt    = bkt_r;
    bhead_nxt  = bhead_r;
    act_nxt    = act_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = 1'b0;
    ent_addr   = '0;
    ent_we     = 1'b0;
    ent_wd     = '{expiry: exp_sum, action: req_r.callback_id, argument: req_r.callback_arg};
    lnk_addr   = '0;
    lnk_we     = 1'b0;
    lnk_wd     = bhead_r[exp_sum[BKT_W-1:0]];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          case (in_data.command)
            CMD_TICK: begin
              now_nxt = now_r + 32'd1;
              if (!in_data.defer) begin
                state_nxt = ST_TICK_CHK;
              end
            end
            CMD_SET: begin
              if (free_r == NONE) begin
                out_v_nxt = 1'b1;
                out_nxt   = '{kind: KIND_SET, status: STAT_NO_FREE, entry: '0,
                              action_id: '0, action_arg: '0, last: 1'b1};
              end else begin
                lnk_addr  = free_r[IDX_W-1:0];
                state_nxt = ST_SET_WR;
              end
            end
            CMD_CANCEL: begin
              if ({1'b0, in_data.handle} < 7'(ENTRIES) &&
                  act_r[in_data.handle[IDX_W-1:0]]) begin
                ent_addr  = in_data.handle[IDX_W-1:0];
                state_nxt = ST_CAN_CHK;
              end else begin
                out_v_nxt = 1'b1;
                out_nxt   = '{kind: KIND_CANCEL, status: STAT_IGNORED,
                              entry: in_data.handle, action_id: '0, action_arg: '0,
                              last: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end

      ST_SET_WR: begin
        free_nxt = lnk_rd;
        ent_addr = free_r[IDX_W-1:0];
        ent_we   = 1'b1;
        lnk_addr = free_r[IDX_W-1:0];
        lnk_we   = 1'b1;
        bhead_nxt[exp_sum[BKT_W-1:0]] = free_r;
        act_nxt[free_r[IDX_W-1:0]]    = 1'b1;
        out_v_nxt = 1'b1;
        out_nxt   = '{kind: KIND_SET, status: STAT_OK, entry: 6'(free_r),
                      action_id: '0, action_arg: '0, last: 1'b1};
        state_nxt = ST_IDLE;
      end

      ST_CAN_CHK: begin
        if (ent_q_r.action == req_r.callback_id && ent_q_r.argument == req_r.callback_arg) begin
          fire_nxt  = 1'b0;
          bkt_nxt   = ent_q_r.expiry[BKT_W-1:0];
          cur_nxt   = bhead_r[ent_q_r.expiry[BKT_W-1:0]];
          prev_nxt  = NONE;
          state_nxt = ST_WALK_RD;
        end else begin
          out_v_nxt = 1'b1;
          out_nxt   = '{kind: KIND_CANCEL, status: STAT_IGNORED, entry: req_r.handle,
                        action_id: '0, action_arg: '0, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end

      ST_TICK_CHK: begin
        if (diff[31]) begin
          state_nxt = ST_IDLE;
        end else begin
          span_nxt  = diff;
          idx_nxt   = '0;
          any_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      // one entry read a cycle; the compare works on the registered read of entry idx-1
      ST_SCAN: begin
        ent_addr = idx_r[IDX_W-1:0];
        idx_nxt  = idx_r + PTR_W'(1);
        if (idx_r != '0 && act_r[j] && d_off <= span_r && (!any_r || d_off < best_r)) begin
          best_nxt = d_off;
          any_nxt  = 1'b1;
        end
        if (idx_r == PTR_W'(ENTRIES)) begin
          state_nxt = ST_SCAN_END;
        end
      end

      ST_SCAN_END: begin
        if (!any_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          tick_nxt  = ndt_r + best_r;
          ndt_nxt   = ndt_r + best_r;
          bkt_nxt   = BKT_W'(ndt_r + best_r);
          cur_nxt   = bhead_r[BKT_W'(ndt_r + best_r)];
          prev_nxt  = NONE;
          fire_nxt  = 1'b1;
          state_nxt = ST_WALK_RD;
        end
      end

      ST_WALK_RD: begin
        if (cur_r == NONE) begin
          // not reached while the lists are well formed
          if (fire_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            act_nxt[req_r.handle[IDX_W-1:0]] = 1'b0;
            out_v_nxt = 1'b1;
            out_nxt   = '{kind: KIND_CANCEL, status: STAT_OK, entry: req_r.handle,
                          action_id: '0, action_arg: '0, last: 1'b1};
            state_nxt = ST_IDLE;
          end
        end else begin
          ent_addr  = cur_r[IDX_W-1:0];
          lnk_addr  = cur_r[IDX_W-1:0];
          state_nxt = ST_WALK_CHK;
        end
      end

      ST_WALK_CHK: begin
        if (hit) begin
          nl_nxt    = lnk_rd;
          state_nxt = ST_UNLINK;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lnk_rd;
          state_nxt = ST_WALK_RD;
        end
      end

      ST_UNLINK: begin
        // reread the entry so its action and argument are there at release
        ent_addr = cur_r[IDX_W-1:0];
        if (prev_r == NONE) begin
          bhead_nxt[bkt_r] = nl_r;
        end else begin
          lnk_addr = prev_r[IDX_W-1:0];
          lnk_we   = 1'b1;
          lnk_wd   = nl_r;
        end
        state_nxt = ST_RELEASE;
      end

      ST_RELEASE: begin
        lnk_addr = cur_r[IDX_W-1:0];
        lnk_we   = 1'b1;
        lnk_wd   = free_r;
        free_nxt = cur_r;
        act_nxt[cur_r[IDX_W-1:0]] = 1'b0;
        if (fire_r) begin
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt   = pend_r;
          end
          pend_nxt   = '{kind: KIND_EXPIRY, status: STAT_OK, entry: 6'(cur_r),
                         action_id: ent_q_r.action, action_arg: ent_q_r.argument,
                         last: 1'b0};
          pend_v_nxt = 1'b1;
          state_nxt  = ST_TICK_CHK;
        end else begin
          out_v_nxt = 1'b1;
          out_nxt   = '{kind: KIND_CANCEL, status: STAT_OK, entry: 6'(cur_r),
                        action_id: '0, action_arg: '0, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        ndt_nxt = now_r + 32'd1;
        if (pend_v_r) begin
          out_v_nxt      = 1'b1;
          out_nxt        = pend_r;
          out_nxt.last   = 1'b1;
          pend_v_nxt     = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

/* sv/htw_checker.sv */
module htw_checker
  import htw_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  logic acc;
  assign acc = start && !busy;

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_EXPIRY |-> out_data.last)
    else $error("set or cancel reply without last");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_EXPIRY |-> out_data.status == STAT_OK)
    else $error("expiry with non-ok status");

  a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_EXPIRY |->
      out_data.action_id == 16'd0 && out_data.action_arg == 32'sd0)
    else $error("reply carries action fields");

  a_defer_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.command == CMD_TICK && in_data.defer |=> !busy && !out_valid)
    else $error("deferred tick did work");

  a_cancel_moves: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.command == CMD_CANCEL |=> busy || out_valid)
    else $error("cancel neither replied nor started");

endmodule

bind hashed_timer_wheel htw_checker u_htw_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
  .out_valid(out_valid), .out_data(out_data)
);
